>>> src/hsv_to_rgb_converter_core_assert.svh
// Assertion macros used by the checker file of the colour converter.
`ifndef HSV_TO_RGB_CONVERTER_CORE_ASSERT_SVH
`define HSV_TO_RGB_CONVERTER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, off while reset is held.
`define HSVRGB_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hsvrgb: same-cycle check failed");

// Next-cycle implication, sampled on the rising edge, off while reset is held.
`define HSVRGB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hsvrgb: next-cycle check failed");

`endif

>>> src/hsvrgb_pkg.sv
`timescale 1ns / 1ps

package hsvrgb_pkg;

	localparam int unsigned HUE_W = 9;
	localparam int unsigned FRAC_W = 9;
	localparam int unsigned CHAN_W = 8;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned NUM_CHAN = 3;

	localparam int unsigned FULL_DEG = 360;
	localparam int unsigned SECTOR_DEG = 60;
	localparam int unsigned ONE_FRAC = 256;
	localparam int unsigned ONE_SECTOR = ONE_FRAC * SECTOR_DEG;

	localparam int unsigned FPART_W = 6;
	localparam int unsigned SPROD_W = 15;
	localparam int unsigned TERM_W = 17;
	localparam int unsigned MPROD_W = 27;
	localparam int unsigned NUM_W = 25;
	localparam int unsigned POS_W = 23;
	localparam int unsigned SCALED_W = 31;
	localparam int unsigned QUOT_SHIFT = 18;
	localparam int unsigned QIN_W = 13;
	localparam int unsigned RECIP_15 = 8739;
	localparam int unsigned RECIP_SHIFT = 17;
	localparam int unsigned QOUT_W = 10;
	localparam int unsigned CHAN_MAX = 255;

	localparam int unsigned CH_RED = 0;
	localparam int unsigned CH_GREEN = 1;
	localparam int unsigned CH_BLUE = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SATURATION = 8'd0,
		REG_BRIGHTNESS = 8'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		SEC_RED_YELLOW,
		SEC_YELLOW_GREEN,
		SEC_GREEN_CYAN,
		SEC_CYAN_BLUE,
		SEC_BLUE_MAGENTA,
		SEC_MAGENTA_RED
	} sector_t;

	typedef logic signed [TERM_W-1:0] term_t;
	typedef logic signed [NUM_W-1:0] num_t;
	typedef logic [CHAN_W-1:0] chan_t;

endpackage

>>> src/hsv_to_rgb_converter_core.sv
// Each hue item passes through the stage 1 to stage 5 registers on its way to the colour output.
// Throughput: one item per clock; the five-stage pipeline only stalls when the output is
// held, and each stage refills as soon as the stage after it has room.
// Reset (arst_n low, asynchronous): the pipeline empties and saturation and brightness
// return to 256, which stands for 1.0.
`timescale 1ns / 1ps

module hsv_to_rgb_converter_core
	import hsvrgb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FRAC_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [HUE_W-1:0]     hue,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CHAN_W-1:0]    red,
	output logic [CHAN_W-1:0]    green,
	output logic [CHAN_W-1:0]    blue
);

	logic [FRAC_W-1:0] sat_q;
	logic [FRAC_W-1:0] bri_q;

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	sector_t            sector_s1;
	logic [FPART_W-1:0] fpart_s1;
	term_t              term_s2 [NUM_CHAN];
	num_t               num_s3 [NUM_CHAN];
	logic [QIN_W-1:0]   quot_in_s4 [NUM_CHAN];
	logic               pos_s4 [NUM_CHAN];
	chan_t              chan_s5 [NUM_CHAN];

	logic [HUE_W-1:0]   hue_eff;
	sector_t            sector_d;
	logic [HUE_W-1:0]   base_d;
	logic [HUE_W-1:0]   fdiff_d;

	logic [SPROD_W-1:0] s_f;
	logic [SPROD_W-1:0] s_rest;
	logic [SPROD_W-1:0] s_full;
	term_t              t_v, t_p, t_q, t_t;
	term_t              term_d [NUM_CHAN];

	logic signed [MPROD_W-1:0] prod_d [NUM_CHAN];
	logic [SCALED_W-1:0]       scaled_d [NUM_CHAN];
	logic [MPROD_W-1:0]        recip_d [NUM_CHAN];
	logic [QOUT_W-1:0]         quot_d [NUM_CHAN];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= FRAC_W'(ONE_FRAC);
			bri_q <= FRAC_W'(ONE_FRAC);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SATURATION: sat_q <= cfg_data;
				REG_BRIGHTNESS: bri_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en_s5 = !valid_s5 || out_ready;
	assign en_s4 = !valid_s4 || en_s5;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= in_valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
		end
	end

	// Stage 1: fold hues past a full turn to zero, then split into sector and offset.
	always_comb begin
		hue_eff = (hue >= HUE_W'(FULL_DEG)) ? '0 : hue;
		if (hue_eff >= HUE_W'(5 * SECTOR_DEG)) begin
			sector_d = SEC_MAGENTA_RED;
			base_d = HUE_W'(5 * SECTOR_DEG);
		end else if (hue_eff >= HUE_W'(4 * SECTOR_DEG)) begin
			sector_d = SEC_BLUE_MAGENTA;
			base_d = HUE_W'(4 * SECTOR_DEG);
		end else if (hue_eff >= HUE_W'(3 * SECTOR_DEG)) begin
			sector_d = SEC_CYAN_BLUE;
			base_d = HUE_W'(3 * SECTOR_DEG);
		end else if (hue_eff >= HUE_W'(2 * SECTOR_DEG)) begin
			sector_d = SEC_GREEN_CYAN;
			base_d = HUE_W'(2 * SECTOR_DEG);
		end else if (hue_eff >= HUE_W'(SECTOR_DEG)) begin
			sector_d = SEC_YELLOW_GREEN;
			base_d = HUE_W'(SECTOR_DEG);
		end else begin
			sector_d = SEC_RED_YELLOW;
			base_d = '0;
		end
		fdiff_d = hue_eff - base_d;
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			sector_s1 <= sector_d;
			fpart_s1 <= fdiff_d[FPART_W-1:0];
		end
	end

	// Stage 2: the four numerators before brightness, each over 256*60.
	always_comb begin
		s_f = SPROD_W'(sat_q) * SPROD_W'(fpart_s1);
		s_rest = SPROD_W'(sat_q) * SPROD_W'(FPART_W'(SECTOR_DEG) - fpart_s1);
		s_full = SPROD_W'(sat_q) * SPROD_W'(SECTOR_DEG);
		t_v = TERM_W'(ONE_SECTOR);
		t_p = TERM_W'(ONE_SECTOR) - $signed({2'b00, s_full});
		t_q = TERM_W'(ONE_SECTOR) - $signed({2'b00, s_f});
		t_t = TERM_W'(ONE_SECTOR) - $signed({2'b00, s_rest});
		unique case (sector_s1)
			SEC_RED_YELLOW: begin
				term_d[CH_RED] = t_v; term_d[CH_GREEN] = t_t; term_d[CH_BLUE] = t_p;
			end
			SEC_YELLOW_GREEN: begin
				term_d[CH_RED] = t_q; term_d[CH_GREEN] = t_v; term_d[CH_BLUE] = t_p;
			end
			SEC_GREEN_CYAN: begin
				term_d[CH_RED] = t_p; term_d[CH_GREEN] = t_v; term_d[CH_BLUE] = t_t;
			end
			SEC_CYAN_BLUE: begin
				term_d[CH_RED] = t_p; term_d[CH_GREEN] = t_q; term_d[CH_BLUE] = t_v;
			end
			SEC_BLUE_MAGENTA: begin
				term_d[CH_RED] = t_t; term_d[CH_GREEN] = t_p; term_d[CH_BLUE] = t_v;
			end
			default: begin
				term_d[CH_RED] = t_v; term_d[CH_GREEN] = t_p; term_d[CH_BLUE] = t_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			for (int c = 0; c < NUM_CHAN; c++) begin
				term_s2[c] <= term_d[c];
			end
		end
	end

	// Stage 3: scale by brightness; stage 4: times 255 and drop the power-of-two part
	// of the denominator; stage 5: divide the rest by 15 and clamp.
	always_comb begin
		for (int c = 0; c < NUM_CHAN; c++) begin
			prod_d[c] = MPROD_W'(term_s2[c]) * MPROD_W'($signed({1'b0, bri_q}));
			scaled_d[c] = {num_s3[c][POS_W-1:0], 8'b0} - SCALED_W'(num_s3[c][POS_W-1:0]);
			recip_d[c] = MPROD_W'(quot_in_s4[c]) * MPROD_W'(RECIP_15);
			quot_d[c] = recip_d[c][MPROD_W-1:RECIP_SHIFT];
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && valid_s2) begin
			for (int c = 0; c < NUM_CHAN; c++) begin
				num_s3[c] <= prod_d[c][NUM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && valid_s3) begin
			for (int c = 0; c < NUM_CHAN; c++) begin
				pos_s4[c] <= !num_s3[c][NUM_W-1] && (num_s3[c] != '0);
				quot_in_s4[c] <= scaled_d[c][SCALED_W-1:QUOT_SHIFT];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && valid_s4) begin
			for (int c = 0; c < NUM_CHAN; c++) begin
				if (!pos_s4[c]) begin
					chan_s5[c] <= '0;
				end else if (quot_d[c] > QOUT_W'(CHAN_MAX)) begin
					chan_s5[c] <= CHAN_W'(CHAN_MAX);
				end else begin
					chan_s5[c] <= quot_d[c][CHAN_W-1:0];
				end
			end
		end
	end

	assign out_valid = valid_s5;
	assign red = chan_s5[CH_RED];
	assign green = chan_s5[CH_GREEN];
	assign blue = chan_s5[CH_BLUE];

endmodule

>>> src/hsvrgb_checker.sv
`timescale 1ns / 1ps
`include "hsv_to_rgb_converter_core_assert.svh"

module hsvrgb_checker
	import hsvrgb_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [FRAC_W-1:0]    cfg_data,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic [HUE_W-1:0]     hue,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [CHAN_W-1:0]    red,
	input logic [CHAN_W-1:0]    green,
	input logic [CHAN_W-1:0]    blue
);

	logic [4:0] acc_hist_q;
	logic [3:0] rdy_hist_q;
	logic       cfg_seen;
	logic       hue_seen;
	logic       path_clear;

	assign cfg_seen = cfg_valid && (cfg_index == cfg_index) && (cfg_data == cfg_data);
	assign hue_seen = in_valid && (hue == hue);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_hist_q <= '0;
			rdy_hist_q <= '0;
		end else begin
			acc_hist_q <= {acc_hist_q[3:0], hue_seen && in_ready};
			rdy_hist_q <= {rdy_hist_q[2:0], out_ready};
		end
	end

	// An item whose acceptance has reached the oldest history bit, with the output taken at every edge since, is out now.
	assign path_clear = acc_hist_q[4] && (&rdy_hist_q);

	`HSVRGB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(red) && $stable(green) && $stable(blue))
	`HSVRGB_ASSERT_IMPL(a_cfg_always_ready, cfg_seen, cfg_ready)
	`HSVRGB_ASSERT_IMPL(a_stall_from_output, !in_ready, out_valid && !out_ready)
	`HSVRGB_ASSERT_IMPL(a_latency, path_clear, out_valid)

endmodule

bind hsv_to_rgb_converter_core hsvrgb_checker u_hsvrgb_checker (.*);

>>> bench/hsv_to_rgb_converter_core_test.sv
`timescale 1ns / 1ps

module hsv_to_rgb_converter_core_test;
	import hsvrgb_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LAST = 8'hFF;
	localparam int PIPE_DEPTH = 5;
	localparam int LONG_HOLD = 64;
	localparam int RANDOM_PHASES = 8;
	localparam int HUES_PER_PHASE = 80;
	localparam longint UNIT = longint'(ONE_FRAC);
	localparam longint DEG_SECTOR = longint'(SECTOR_DEG);
	localparam longint DEG_FULL = longint'(FULL_DEG);
	localparam longint CH_TOP = longint'(CHAN_MAX);
	localparam longint SCALE_DENOM = UNIT * UNIT * DEG_SECTOR;

	typedef struct packed {
		chan_t red;
		chan_t green;
		chan_t blue;
	} colour_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [FRAC_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [HUE_W-1:0] hue = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;

	logic [HUE_W-1:0] hue_pending[$];
	colour_t colour_expected[$];
	colour_t colour_want;
	logic [FRAC_W-1:0] sat_shadow = 9'd256;
	logic [FRAC_W-1:0] bright_shadow = 9'd256;
	bit quiet = 1'b0;
	bit hold_request = 1'b0;
	bit hold_done = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	int hues_sent = 0;
	int colours_checked = 0;
	int settings_used = 0;
	int fails = 0;

	hsv_to_rgb_converter_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.hue(hue),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.red(red),
		.green(green),
		.blue(blue)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		#2_000_000;
		$display("[hsv_to_rgb_converter_core] ERROR");
		$finish;
	end

	function automatic chan_t scale_channel(longint num);
		longint c;
		if (num <= 0) begin
			return '0;
		end
		c = (num * CH_TOP) / SCALE_DENOM;
		if (c > CH_TOP) begin
			c = CH_TOP;
		end
		return chan_t'(c);
	endfunction

	function automatic colour_t predict_colour(logic [HUE_W-1:0] h_in,
		logic [FRAC_W-1:0] s_in, logic [FRAC_W-1:0] v_in);
		longint h, s, v, sector, f, nv, np, nq, nt, r, g, b;
		colour_t c;
		h = longint'(h_in);
		s = longint'(s_in);
		v = longint'(v_in);
		if (h >= DEG_FULL) begin
			h = 0;
		end
		sector = h / DEG_SECTOR;
		f = h % DEG_SECTOR;
		nv = v * UNIT * DEG_SECTOR;
		np = v * (UNIT - s) * DEG_SECTOR;
		nq = v * (UNIT * DEG_SECTOR - s * f);
		nt = v * (UNIT * DEG_SECTOR - s * (DEG_SECTOR - f));
		case (sector_t'(sector))
			SEC_RED_YELLOW: begin
				r = nv; g = nt; b = np;
			end
			SEC_YELLOW_GREEN: begin
				r = nq; g = nv; b = np;
			end
			SEC_GREEN_CYAN: begin
				r = np; g = nv; b = nt;
			end
			SEC_CYAN_BLUE: begin
				r = np; g = nq; b = nv;
			end
			SEC_BLUE_MAGENTA: begin
				r = nt; g = np; b = nv;
			end
			default: begin
				r = nv; g = np; b = nq;
			end
		endcase
		c.red = scale_channel(r);
		c.green = scale_channel(g);
		c.blue = scale_channel(b);
		return c;
	endfunction

	// Leaves cfg_valid high so that writes can follow one another without a gap.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [FRAC_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (index == REG_SATURATION) begin
			sat_shadow = data;
		end else if (index == REG_BRIGHTNESS) begin
			bright_shadow = data;
		end
	endtask

	task automatic apply_setting(input logic [FRAC_W-1:0] sat, input logic [FRAC_W-1:0] bright,
		input bit with_stray);
		if (with_stray) begin
			write_reg(REG_UNUSED, 9'h1FF);
			write_reg(REG_LAST, 9'h000);
		end
		write_reg(REG_SATURATION, sat);
		write_reg(REG_BRIGHTNESS, bright);
		cfg_valid <= 1'b0;
		settings_used++;
		@(posedge clk);
	endtask

	task automatic drain_pipeline();
		while (hue_pending.size() != 0 || in_valid || colour_expected.size() != 0)
			@(posedge clk);
		repeat (3 * PIPE_DEPTH) @(posedge clk);
	endtask

	// Mostly hues in the circle, with some of the wrapped range above it.
	task automatic queue_random_hues(input int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 7) == 0) begin
				hue_pending.push_back(HUE_W'($urandom_range(FULL_DEG, 511)));
			end else begin
				hue_pending.push_back(HUE_W'($urandom_range(0, FULL_DEG - 1)));
			end
		end
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				colour_expected.push_back(predict_colour(hue, sat_shadow, bright_shadow));
				hues_sent++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (!quiet && hue_pending.size() != 0 && $urandom_range(0, 4) == 0) begin
					send_gap = $urandom_range(0, 5);
					in_valid <= 1'b0;
				end else if (hue_pending.size() != 0) begin
					in_valid <= 1'b1;
					hue <= hue_pending.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (colour_expected.size() == 0) begin
					$error("colour item with none expected: red %0d green %0d blue %0d",
						red, green, blue);
					fails++;
				end else begin
					colour_want = colour_expected.pop_front();
					colours_checked++;
					if (red !== colour_want.red) begin
						$error("red: expected %0d, got %0d", colour_want.red, red);
						fails++;
					end
					if (green !== colour_want.green) begin
						$error("green: expected %0d, got %0d", colour_want.green, green);
						fails++;
					end
					if (blue !== colour_want.blue) begin
						$error("blue: expected %0d, got %0d", colour_want.blue, blue);
						fails++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 5);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [FRAC_W-1:0] sat;
		logic [FRAC_W-1:0] bright;
		while (!arst_n) @(posedge clk);
		@(posedge clk);

		// Sector boundaries and the wrapped range at the reset setting.
		hue_pending.push_back(9'd0);
		hue_pending.push_back(9'd59);
		hue_pending.push_back(9'd60);
		hue_pending.push_back(9'd119);
		hue_pending.push_back(9'd120);
		hue_pending.push_back(9'd179);
		hue_pending.push_back(9'd180);
		hue_pending.push_back(9'd239);
		hue_pending.push_back(9'd240);
		hue_pending.push_back(9'd299);
		hue_pending.push_back(9'd300);
		hue_pending.push_back(9'd359);
		hue_pending.push_back(9'd360);
		hue_pending.push_back(9'd511);
		hue_pending.push_back(9'd1);
		hue_pending.push_back(9'd30);
		drain_pipeline();

		// Grey, with stray register indexes that must leave the setting alone.
		apply_setting(9'd0, 9'd200, 1'b1);
		hue_pending.push_back(9'd0);
		hue_pending.push_back(9'd100);
		hue_pending.push_back(9'd400);
		drain_pipeline();

		// Overdriven saturation and brightness: negative terms and clipping.
		apply_setting(9'h1FF, 9'h1FF, 1'b0);
		hue_pending.push_back(9'd0);
		hue_pending.push_back(9'd30);
		hue_pending.push_back(9'd90);
		hue_pending.push_back(9'd200);
		hue_pending.push_back(9'd511);
		drain_pipeline();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin
					sat = 9'd0; bright = 9'd0;
				end
				1: begin
					sat = 9'd256; bright = 9'd256;
				end
				2: begin
					sat = 9'h1FF; bright = 9'd0;
				end
				3: begin
					sat = 9'd0; bright = 9'h1FF;
				end
				4: begin
					sat = 9'd256; bright = 9'd1;
				end
				default: begin
					sat = FRAC_W'($urandom_range(0, 511));
					bright = FRAC_W'($urandom_range(0, 511));
				end
			endcase
			apply_setting(sat, bright, phase == 5);
			quiet = (phase == RANDOM_PHASES - 1) || ($urandom_range(0, 3) == 0);
			queue_random_hues(HUES_PER_PHASE);
			if (phase == 2) begin
				hold_request = 1'b1;
			end
			drain_pipeline();
		end

		$display("Converted and checked %0d hue items (%0d colour items) over %0d settings,",
			hues_sent, colours_checked, settings_used + 1);
		$display("covering grey, zero and overdriven brightness, wrapped hues and a full stall.");
		if (fails == 0) begin
			$display("[hsv_to_rgb_converter_core] OK");
		end else begin
			$display("[hsv_to_rgb_converter_core] ERROR");
		end
		$finish;
	end

endmodule
